// ===== hdl/spn_pkg.sv =====
package spn_pkg;

   // Defaults for the top-level parameters
   localparam int DEFAULT_NEEDLE_MAX  = 1023;
   localparam int DEFAULT_TIMER_WIDTH = 16;

   // Field widths
   localparam int SCALE_W     = 32;
   localparam int OFFSET_W    = 10;
   localparam int PERIOD_W    = 16;
   localparam int SHIFT_W     = 4;
   localparam int PPR_W       = 4;
   localparam int ODO_W       = 8;
   localparam int POS_W       = 10;
   localparam int PHASE_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Item queue and divider sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int DIV_STEPS   = SCALE_W;

   localparam logic [PHASE_W-1:0]  PHASE_LAST = PHASE_W'(5);
   localparam logic [ODO_W-1:0]    ODO_FULL   = '1;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

   // Register reset values
   localparam logic [SCALE_W-1:0]  RST_SPEED_SCALE     = SCALE_W'(2834000);
   localparam logic [OFFSET_W-1:0] RST_ZERO_OFFSET     = '0;
   localparam logic [PERIOD_W-1:0] RST_NOISE_FLOOR     = PERIOD_W'(3500);
   localparam logic [SHIFT_W-1:0]  RST_FILTER_SHIFT    = SHIFT_W'(2);
   localparam logic [PPR_W-1:0]    RST_PULSES_PER_REV  = PPR_W'(3);
   localparam logic [ODO_W-1:0]    RST_ODOMETER_PULSES = ODO_W'(15);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED_SCALE,
      CSR_ZERO_OFFSET,
      CSR_NOISE_FLOOR,
      CSR_FILTER_SHIFT,
      CSR_PULSES_PER_REV,
      CSR_ODOMETER_PULSES
   } csr_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0]  speed_scale;
      logic [OFFSET_W-1:0] zero_offset_steps;
      logic [PERIOD_W-1:0] noise_floor;
      logic [SHIFT_W-1:0]  filter_shift;
      logic [PPR_W-1:0]    pulses_per_rev;
      logic [ODO_W-1:0]    odometer_pulses;
   } cfg_type;

   // One queued tick
   typedef struct packed {
      logic pulse;
      logic strobe;
   } item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_EMIT
   } back_state_type;

endpackage

// ===== hdl/spn_req_if.sv =====
interface spn_req_if;
   logic valid;
   logic ready;
   logic sensor_pulse;
   logic step_strobe;

   modport source (output valid, output sensor_pulse, output step_strobe, input ready);
   modport sink   (input valid, input sensor_pulse, input step_strobe, output ready);
endinterface

// ===== hdl/spn_rsp_if.sv =====
interface spn_rsp_if;
   import spn_pkg::*;

   logic                valid;
   logic                ready;
   logic [POS_W-1:0]    needle_position;
   logic [PHASE_W-1:0]  needle_phase;
   logic                odometer_advance;
   logic [PERIOD_W-1:0] filtered_period;

   modport source (output valid, output needle_position, output needle_phase,
                   output odometer_advance, output filtered_period, input ready);
   modport sink   (input valid, input needle_position, input needle_phase,
                   input odometer_advance, input filtered_period, output ready);
endinterface

// ===== hdl/spn_front.sv =====
module spn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_sensor_pulse,
   input  logic              req_step_strobe,
   output logic              head_valid,
   output spn_pkg::item_type head,
   input  logic              pop
);
   import spn_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, take;
   item_type          incoming;

   assign req_ready  = (count_ff != CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign take       = pop && head_valid;

   // Tag the word by the work it asks of the back end
   always_comb begin
      incoming.pulse  = req_sensor_pulse;
      incoming.strobe = req_step_strobe;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// ===== hdl/spn_div.sv =====
module spn_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [spn_pkg::SCALE_W-1:0]      dividend,
   input  logic [spn_pkg::PERIOD_W-1:0]     divisor,
   output spn_pkg::div_status_type          status,
   output logic [spn_pkg::SCALE_W-1:0]      quotient
);
   import spn_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   logic [SCALE_W-1:0]  quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [PERIOD_W:0]   trial;
   logic                fits;

   // Restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[SCALE_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SCALE_W-2:0], fits};
         rem_in = fits ? PERIOD_W'(trial - {1'b0, dvs_ff}) : trial[PERIOD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== hdl/spn_back.sv =====
module spn_back #(
   parameter int NEEDLE_MAX  = spn_pkg::DEFAULT_NEEDLE_MAX,
   parameter int TIMER_WIDTH = spn_pkg::DEFAULT_TIMER_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spn_pkg::cfg_type              cfg,
   input  logic                          item_valid,
   input  spn_pkg::item_type             item,
   output logic                          item_pop,
   output logic                          div_start,
   output logic [spn_pkg::SCALE_W-1:0]   div_dividend,
   output logic [spn_pkg::PERIOD_W-1:0]  div_divisor,
   input  spn_pkg::div_status_type       div_status,
   input  logic [spn_pkg::SCALE_W-1:0]   div_quotient,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [spn_pkg::POS_W-1:0]     needle_position,
   output logic [spn_pkg::PHASE_W-1:0]   needle_phase,
   output logic                          odometer_advance,
   output logic [spn_pkg::PERIOD_W-1:0]  filtered_period
);
   import spn_pkg::*;

   localparam int STEPS_W = $clog2(NEEDLE_MAX + 1);
   localparam int CMP_W   = (TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W;
   localparam int FILT_W  = CMP_W + 2;
   localparam logic [STEPS_W-1:0] STEPS_MAX = STEPS_W'(NEEDLE_MAX);
   localparam logic [SCALE_W-1:0] TARGET_MAX = SCALE_W'(NEEDLE_MAX);

   back_state_type state_ff, state_in;

   logic [TIMER_WIDTH-1:0] tick_ff, tick_in;
   logic [PPR_W-1:0]       pulse_cnt_ff, pulse_cnt_in;
   logic [ODO_W-1:0]       odo_cnt_ff, odo_cnt_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic [STEPS_W-1:0]     steps_ff, steps_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic                   strobe_ff, strobe_in;
   logic [SCALE_W-1:0]     quo_ff, quo_in;

   logic                   out_valid_ff, out_valid_in;
   logic [POS_W-1:0]       out_pos_ff, out_pos_in;
   logic [PHASE_W-1:0]     out_phase_ff, out_phase_in;
   logic                   out_adv_ff, out_adv_in;
   logic [PERIOD_W-1:0]    out_period_ff, out_period_in;

   // Tick-side values for the word at the head of the queue
   logic [TIMER_WIDTH-1:0] tick_inc;
   logic                   overflow;
   logic [PERIOD_W-1:0]    period_base;
   logic [PPR_W-1:0]       pc_base, pc_inc;
   logic                   rev_done, above_floor;
   logic signed [FILT_W-1:0] diff, fstep, fsum;
   logic [PERIOD_W-1:0]    period_filt, period_pop;
   logic [TIMER_WIDTH-1:0] tick_pop;
   logic [PPR_W-1:0]       pc_pop;
   logic [ODO_W-1:0]       odo_pop;

   // Needle-side values
   logic [SCALE_W-1:0]     target_raw;
   logic [STEPS_W-1:0]     target;
   logic                   step_up, step_dn, advance;
   logic                   out_free, emit_go;

   always_comb begin
      tick_inc    = tick_ff + 1'b1;
      overflow    = (tick_inc == '0);
      period_base = overflow ? '0 : period_ff;
      pc_base     = overflow ? '0 : pulse_cnt_ff;
      pc_inc      = pc_base + 1'b1;
      rev_done    = item.pulse && (pc_inc >= cfg.pulses_per_rev);
      above_floor = (CMP_W'(tick_inc) > CMP_W'(cfg.noise_floor));

      // Low pass: arithmetic shift floors toward minus infinity
      diff  = $signed({2'b00, CMP_W'(tick_inc)}) - $signed({2'b00, CMP_W'(period_base)});
      fstep = diff >>> cfg.filter_shift;
      fsum  = $signed({2'b00, CMP_W'(period_base)}) + fstep;
      if (fsum[FILT_W-1]) begin
         period_filt = '0;
      end else if (|fsum[FILT_W-2:PERIOD_W]) begin
         period_filt = PERIOD_MAX;
      end else begin
         period_filt = fsum[PERIOD_W-1:0];
      end

      period_pop = (rev_done && above_floor) ? period_filt : period_base;
      tick_pop   = rev_done ? '0 : tick_inc;
      pc_pop     = rev_done ? '0 : (item.pulse ? pc_inc : pc_base);
      odo_pop    = (item.pulse && (odo_cnt_ff != ODO_FULL)) ? odo_cnt_ff + 1'b1 : odo_cnt_ff;
   end

   always_comb begin
      target_raw = (quo_ff > SCALE_W'(cfg.zero_offset_steps)) ?
                   quo_ff - SCALE_W'(cfg.zero_offset_steps) : '0;
      target     = (target_raw > TARGET_MAX) ? STEPS_MAX : STEPS_W'(target_raw);
      step_up    = strobe_ff && (steps_ff < target);
      step_dn    = strobe_ff && (steps_ff > target);
      advance    = strobe_ff && (odo_cnt_ff >= cfg.odometer_pulses);
   end

   assign out_free = !out_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               state_in = (item.strobe && (period_pop != '0)) ? BK_DIV : BK_EMIT;
            end
         end
         BK_DIV: begin
            if (div_status.done) state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      item_pop  = 1'b0;
      div_start = 1'b0;
      emit_go   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            item_pop  = item_valid;
            div_start = item_valid && item.strobe && (period_pop != '0);
         end
         BK_EMIT: emit_go = out_free;
         default: ;
      endcase
   end

   assign div_dividend = cfg.speed_scale;
   assign div_divisor  = period_pop;

   always_comb begin
      tick_in      = tick_ff;
      pulse_cnt_in = pulse_cnt_ff;
      odo_cnt_in   = odo_cnt_ff;
      period_in    = period_ff;
      steps_in     = steps_ff;
      phase_in     = phase_ff;
      strobe_in    = strobe_ff;
      quo_in       = quo_ff;
      out_pos_in    = out_pos_ff;
      out_phase_in  = out_phase_ff;
      out_adv_in    = out_adv_ff;
      out_period_in = out_period_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (item_pop) begin
         tick_in      = tick_pop;
         pulse_cnt_in = pc_pop;
         odo_cnt_in   = odo_pop;
         period_in    = period_pop;
         strobe_in    = item.strobe;
         quo_in       = '0;
      end

      if ((state_ff == BK_DIV) && div_status.done) begin
         quo_in = div_quotient;
      end

      if (emit_go) begin
         if (step_up) begin
            steps_in = steps_ff + 1'b1;
            phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 1'b1;
         end else if (step_dn) begin
            steps_in = steps_ff - 1'b1;
            phase_in = (phase_ff == '0) ? PHASE_LAST : phase_ff - 1'b1;
         end
         if (advance) odo_cnt_in = '0;
         out_valid_in  = 1'b1;
         out_pos_in    = POS_W'(steps_in);
         out_phase_in  = phase_in;
         out_adv_in    = advance;
         out_period_in = period_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         tick_ff      <= '0;
         pulse_cnt_ff <= '0;
         odo_cnt_ff   <= '0;
         period_ff    <= '0;
         steps_ff     <= '0;
         phase_ff     <= '0;
         strobe_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         pulse_cnt_ff <= pulse_cnt_in;
         odo_cnt_ff   <= odo_cnt_in;
         period_ff    <= period_in;
         steps_ff     <= steps_in;
         phase_ff     <= phase_in;
         strobe_ff    <= strobe_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff        <= quo_in;
      out_pos_ff    <= out_pos_in;
      out_phase_ff  <= out_phase_in;
      out_adv_ff    <= out_adv_in;
      out_period_ff <= out_period_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign needle_position  = out_pos_ff;
   assign needle_phase     = out_phase_ff;
   assign odometer_advance = out_adv_ff;
   assign filtered_period  = out_period_ff;

endmodule

// ===== hdl/speedo_period_to_needle_unit.sv =====
// A word without a strobe, or with a zero period, passes from the queue straight to the
// result register; a strobe tick with a nonzero period first waits on the 32-step divider.
// The back end takes no new word until it has emitted the last one; its single
// divider sets the pace, and the queue absorbs bursts.
// Reset (synchronous, active high): registers take their defaults, the counters,
// period and needle clear to zero, the queue empties and no result is shown.
module speedo_period_to_needle_unit #(
   parameter int NEEDLE_MAX  = spn_pkg::DEFAULT_NEEDLE_MAX,
   parameter int TIMER_WIDTH = spn_pkg::DEFAULT_TIMER_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   spn_req_if.sink                           req_ch,
   spn_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [spn_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spn_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import spn_pkg::*;

   // Configuration registers; writes to unknown indexes are dropped
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SPEED_SCALE:     cfg_in.speed_scale       = csr_wdata[SCALE_W-1:0];
            CSR_ZERO_OFFSET:     cfg_in.zero_offset_steps = csr_wdata[OFFSET_W-1:0];
            CSR_NOISE_FLOOR:     cfg_in.noise_floor       = csr_wdata[PERIOD_W-1:0];
            CSR_FILTER_SHIFT:    cfg_in.filter_shift      = csr_wdata[SHIFT_W-1:0];
            CSR_PULSES_PER_REV:  cfg_in.pulses_per_rev    = csr_wdata[PPR_W-1:0];
            CSR_ODOMETER_PULSES: cfg_in.odometer_pulses   = csr_wdata[ODO_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_scale       <= RST_SPEED_SCALE;
         cfg_ff.zero_offset_steps <= RST_ZERO_OFFSET;
         cfg_ff.noise_floor       <= RST_NOISE_FLOOR;
         cfg_ff.filter_shift      <= RST_FILTER_SHIFT;
         cfg_ff.pulses_per_rev    <= RST_PULSES_PER_REV;
         cfg_ff.odometer_pulses   <= RST_ODOMETER_PULSES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: take words off the input channel into a short queue
   logic           head_valid;
   item_type       head;
   logic           head_pop;

   spn_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_sensor_pulse (req_ch.sensor_pulse),
      .req_step_strobe  (req_ch.step_strobe),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (head_pop)
   );

   // Single iterative divider: speed_scale over the filtered period
   logic                div_start;
   logic [SCALE_W-1:0]  div_dividend;
   logic [PERIOD_W-1:0] div_divisor;
   div_status_type      div_status;
   logic [SCALE_W-1:0]  div_quotient;

   spn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Back end: tick timing, filter, needle step and the result register.
   // The result register holds a finished word while the queue keeps filling.
   spn_back #(
      .NEEDLE_MAX  (NEEDLE_MAX),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .item_valid       (head_valid),
      .item             (head),
      .item_pop         (head_pop),
      .div_start        (div_start),
      .div_dividend     (div_dividend),
      .div_divisor      (div_divisor),
      .div_status       (div_status),
      .div_quotient     (div_quotient),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .needle_position  (rsp_ch.needle_position),
      .needle_phase     (rsp_ch.needle_phase),
      .odometer_advance (rsp_ch.odometer_advance),
      .filtered_period  (rsp_ch.filtered_period)
   );

endmodule

// ===== hdl/spn_checker.sv =====
module spn_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [spn_pkg::POS_W-1:0]      needle_position,
   input logic [spn_pkg::PHASE_W-1:0]    needle_phase,
   input logic                           odometer_advance,
   input logic [spn_pkg::PERIOD_W-1:0]   filtered_period
);
   import spn_pkg::*;

   logic [7:0]         outstanding_ff, outstanding_in;
   logic               have_last_ff;
   logic [POS_W-1:0]   last_pos_ff;
   logic [PHASE_W-1:0] last_phase_ff;
   logic               req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      case ({req_take, rsp_take})
         2'b10:   outstanding_in = outstanding_ff + 1'b1;
         2'b01:   outstanding_in = outstanding_ff - 1'b1;
         default: outstanding_in = outstanding_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         have_last_ff   <= 1'b0;
         last_pos_ff    <= '0;
         last_phase_ff  <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
         if (rsp_take) begin
            have_last_ff  <= 1'b1;
            last_pos_ff   <= needle_position;
            last_phase_ff <= needle_phase;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(needle_position) &&
      $stable(needle_phase) && $stable(odometer_advance) && $stable(filtered_period))
      else $error("result word changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != '0)
      else $error("result without an accepted word");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && have_last_ff |-> needle_position == last_pos_ff ||
      needle_position == POS_W'(last_pos_ff + 1'b1) ||
      needle_position == POS_W'(last_pos_ff - 1'b1))
      else $error("needle moved more than one step");

   a_phase_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_take && have_last_ff && needle_position == last_pos_ff |->
      needle_phase == last_phase_ff)
      else $error("phase changed without a step");

endmodule

bind speedo_period_to_needle_unit spn_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .needle_position  (rsp_ch.needle_position),
   .needle_phase     (rsp_ch.needle_phase),
   .odometer_advance (rsp_ch.odometer_advance),
   .filtered_period  (rsp_ch.filtered_period)
);
